// ----- rtl/core/sapc_pkg.sv -----
// Shared types and constants for the source address packet counter.
package sapc_pkg;

  // Default number of table entries.
  localparam int DefaultEntries = 64;

  // Port widths fixed by the item format.
  localparam int AddrW    = 32;
  localparam int CountW   = 32;
  localparam int IndexW   = 6;
  localparam int UsedW    = 7;

  // Largest packet count; a hit on an entry at this value leaves it there.
  localparam logic [CountW-1:0] CountMax = '1;

  // Result status codes.
  typedef enum logic [1:0] {
    StHit  = 2'd0,
    StNew  = 2'd1,
    StFull = 2'd2,
    StRead = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    StateIdle,
    StateDecode,
    StateReadOut,
    StateScan
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture the input item
    logic    scan_init;  // rewind the scan pointer
    logic    issue_scan; // read the table at the scan pointer
    logic    issue_idx;  // read the table at the requested index
    logic    write_hit;  // write the incremented count of the matching entry
    logic    write_new;  // append the item's address with a count of one
    logic    emit;       // load the result registers and raise the strobe
    status_e status;     // which result to form
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;    // the captured item is a read
    logic scan_more;  // entries remain to be read by the scan
    logic match;      // the last entry read holds the item's address
    logic full;       // every entry is in use
  } ctrl_sts_t;

endpackage

// ----- rtl/core/source_address_packet_counter.sv -----
// Top level of the per-source-address packet counter table.
//
// Command channel: an item is taken at a rising edge where start is high and
// busy is low. A count item (action_i = 0) looks up source_addr_i in the
// table; a read item (action_i = 1) returns the entry at entry_index_i.
// Each item gives exactly one result, shown for one cycle with done_o high.
// The receiver cannot stall, so it must take the result in that cycle.
// Entries fill from index 0 in order of first appearance; counts saturate.
//
// A read item reads the table at the requested index in the decode state
// and loads the result registers in the read-out state. A count item
// searches the used entries one per cycle through the table read port,
// until a match or, on a miss, until all used entries have been read.
// busy drops in the cycle the result is shown, so the next item can be
// taken while done_o is high.
//
// Reset clears the fill count and the control state at once; the table
// contents need no clearing, as only entries below the fill count are read.
module source_address_packet_counter #(
  parameter int Entries = sapc_pkg::DefaultEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [sapc_pkg::AddrW-1:0]    source_addr_i,
  input  logic [sapc_pkg::IndexW-1:0]   entry_index_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [sapc_pkg::AddrW-1:0]    entry_addr_o,
  output logic [sapc_pkg::CountW-1:0]   entry_count_o,
  output logic                          entry_valid_o,
  output logic [sapc_pkg::UsedW-1:0]    used_entries_o
);
  import sapc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  sapc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Table and result datapath.
  sapc_datapath #(
    .Entries (Entries)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .source_addr_i  (source_addr_i),
    .entry_index_i  (entry_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entry_addr_o   (entry_addr_o),
    .entry_count_o  (entry_count_o),
    .entry_valid_o  (entry_valid_o),
    .used_entries_o (used_entries_o)
  );

endmodule

// ----- rtl/core/sapc_ctrl.sv -----
// Controller state machine that sequences the table search and reads.
module sapc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sapc_pkg::ctrl_sts_t sts_i,
  output sapc_pkg::ctrl_cmd_t cmd_o
);
  import sapc_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateIdle: begin
        if (start) begin
          state_d = StateDecode;
        end
      end
      StateDecode: begin
        state_d = sts_i.is_read ? StateReadOut : StateScan;
      end
      StateReadOut: begin
        state_d = StateIdle;
      end
      StateScan: begin
        // The search ends on a match or once no entry is left to read.
        if (sts_i.match || !sts_i.scan_more) begin
          state_d = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.status = StHit;
    unique case (state_q)
      StateIdle: begin
        cmd_o.load = start;
      end
      StateDecode: begin
        cmd_o.scan_init = 1'b1;
        cmd_o.issue_idx = sts_i.is_read;
      end
      StateReadOut: begin
        cmd_o.emit   = 1'b1;
        cmd_o.status = StRead;
      end
      StateScan: begin
        if (sts_i.match) begin
          cmd_o.write_hit = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.status    = StHit;
        end else if (sts_i.scan_more) begin
          cmd_o.issue_scan = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StFull;
        end else begin
          cmd_o.write_new = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.status    = StNew;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy = (state_q != StateIdle);

endmodule

// ----- rtl/core/sapc_datapath.sv -----
// Datapath: address and count tables, scan pointer and result registers.
module sapc_datapath #(
  parameter int Entries = sapc_pkg::DefaultEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sapc_pkg::ctrl_cmd_t           cmd_i,
  output sapc_pkg::ctrl_sts_t           sts_o,
  input  logic                          action_i,
  input  logic [sapc_pkg::AddrW-1:0]    source_addr_i,
  input  logic [sapc_pkg::IndexW-1:0]   entry_index_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [sapc_pkg::AddrW-1:0]    entry_addr_o,
  output logic [sapc_pkg::CountW-1:0]   entry_count_o,
  output logic                          entry_valid_o,
  output logic [sapc_pkg::UsedW-1:0]    used_entries_o
);
  import sapc_pkg::*;

  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam int CmpW = (CntW > IndexW) ? CntW : IndexW;

  // Table memories.
  logic [AddrW-1:0]  addr_mem [Entries];
  logic [CountW-1:0] cnt_mem  [Entries];

  // Captured item.
  logic              action_q;
  logic [AddrW-1:0]  addr_q;
  logic [IndexW-1:0] idx_q;

  // Control state.
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            rd_vld_q;
  logic            done_q;

  // Read data and the entry it came from.
  logic [AddrW-1:0]  rd_addr_q;
  logic [CountW-1:0] rd_cnt_q;
  logic [IdxW-1:0]   rd_idx_q;

  // Result registers.
  status_e           res_status_q;
  logic [AddrW-1:0]  res_addr_q;
  logic [CountW-1:0] res_cnt_q;
  logic              res_valid_q;
  logic [UsedW-1:0]  res_used_q;

  logic [IdxW-1:0]   raddr;
  logic [CountW-1:0] cnt_inc;
  logic              read_ok;
  logic [AddrW-1:0]  res_addr_d;
  logic [CountW-1:0] res_cnt_d;
  logic              res_valid_d;

  // Capture the item when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      addr_q   <= source_addr_i;
      idx_q    <= entry_index_i;
    end
  end

  // A read hits only an entry below the fill count.
  assign read_ok = CmpW'(idx_q) < CmpW'(used_q);

  // Table read address: the scan pointer or the requested index.
  assign raddr = cmd_i.issue_idx ? IdxW'(idx_q) : ptr_q[IdxW-1:0];

  // Table read with registered data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_scan || cmd_i.issue_idx) begin
      rd_addr_q <= addr_mem[raddr];
      rd_cnt_q  <= cnt_mem[raddr];
      rd_idx_q  <= raddr;
    end
  end

  // Saturating increment of the count just read.
  assign cnt_inc = (rd_cnt_q == CountMax) ? rd_cnt_q : rd_cnt_q + CountW'(1);

  // Table writes: count update on a hit, new entry on an append.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_hit) begin
      cnt_mem[rd_idx_q] <= cnt_inc;
    end else if (cmd_i.write_new) begin
      addr_mem[used_q[IdxW-1:0]] <= addr_q;
      cnt_mem[used_q[IdxW-1:0]]  <= CountW'(1);
    end
  end

  // Scan pointer and fill count.
  always_comb begin
    ptr_d  = ptr_q;
    used_d = used_q;
    if (cmd_i.scan_init) begin
      ptr_d = '0;
    end else if (cmd_i.issue_scan) begin
      ptr_d = ptr_q + CntW'(1);
    end
    if (cmd_i.write_new) begin
      used_d = used_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      used_q   <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      used_q   <= used_d;
      rd_vld_q <= cmd_i.issue_scan;
      done_q   <= cmd_i.emit;
    end
  end

  // Result fields for each kind of result.
  always_comb begin
    res_addr_d  = addr_q;
    res_cnt_d   = '0;
    res_valid_d = 1'b0;
    case (cmd_i.status)
      StHit: begin
        res_cnt_d   = cnt_inc;
        res_valid_d = 1'b1;
      end
      StNew: begin
        res_cnt_d   = CountW'(1);
        res_valid_d = 1'b1;
      end
      StFull: begin
        res_cnt_d   = '0;
        res_valid_d = 1'b0;
      end
      StRead: begin
        res_addr_d  = read_ok ? rd_addr_q : '0;
        res_cnt_d   = read_ok ? rd_cnt_q : '0;
        res_valid_d = read_ok;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_status_q <= cmd_i.status;
      res_addr_q   <= res_addr_d;
      res_cnt_q    <= res_cnt_d;
      res_valid_q  <= res_valid_d;
      res_used_q   <= UsedW'(used_d);
    end
  end

  // Status for the controller.
  assign sts_o.is_read   = action_q;
  assign sts_o.scan_more = ptr_q < used_q;
  assign sts_o.match     = rd_vld_q && (rd_addr_q == addr_q);
  assign sts_o.full      = used_q == CntW'(Entries);

  assign done_o         = done_q;
  assign status_o       = res_status_q;
  assign entry_addr_o   = res_addr_q;
  assign entry_count_o  = res_cnt_q;
  assign entry_valid_o  = res_valid_q;
  assign used_entries_o = res_used_q;

endmodule

// ----- rtl/core/sapc_checker.sv -----
// Port-level checks for the source address packet counter, with its bind.
module sapc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [1:0]                    status_o,
  input logic [sapc_pkg::CountW-1:0]   entry_count_o,
  input logic                          entry_valid_o
);
  import sapc_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted item did not make the block busy.");

  // Each item passes through the decode state before its result is formed, so results never come back to back.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  // A full table reports an invalid entry with a zero count.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StFull) |-> (!entry_valid_o && entry_count_o == '0))
    else $error("Table full result carries entry data.");

  // A new entry starts at a count of one.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StNew) |-> (entry_valid_o && entry_count_o == CountW'(1)))
    else $error("New entry result has a wrong count.");

  // A hit always reports a valid entry with a nonzero count.
  a_hit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StHit) |-> (entry_valid_o && entry_count_o != '0))
    else $error("Hit result has an invalid entry or zero count.");

endmodule

bind source_address_packet_counter sapc_checker u_sapc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o),
  .entry_valid_o (entry_valid_o)
);
